>>> rtl/core/blur3_pkg.sv
// Shared types and constants for the 3x3 edge-normalized blur.
// Holds sizes, controller state codes, command/status structs and the
// reciprocal table for the weight totals. No dependencies.
package blur3_pkg;

  // Frame and channel limits
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int MAX_CHANNELS = 3;

  // Field and counter widths
  localparam int SAMPLE_W = 8;
  localparam int DIM_W    = 11;
  localparam int CHAN_W   = 2;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  // Line store: two lines per channel, packed side by side in one word
  localparam int LS_DEPTH = MAX_CHANNELS * MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int LS_DW    = 2 * SAMPLE_W;

  // Weighted sum and divider widths
  localparam int SUM_W   = 12;
  localparam int TOT_W   = 5;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_KERNEL_SELECT = 2'd3
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SUM  = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch sample, issue line store read
    logic update;    // write line store, shift window, form sum
    logic load_out;  // move quotient into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic res_valid; // the item in flight produces a result
    logic out_busy;  // output register holds a result that stays
  } status_t;

  // Reciprocal ceil(2^20 / d) for every weight total that can occur;
  // exact truncating quotient for sums below 2^12.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [TOT_W-1:0] d);
    logic [RECIP_W-1:0] m;
    unique case (d)
      5'd1:    m = 21'd1048576;
      5'd2:    m = 21'd524288;
      5'd3:    m = 21'd349526;
      5'd4:    m = 21'd262144;
      5'd6:    m = 21'd174763;
      5'd8:    m = 21'd131072;
      5'd9:    m = 21'd116509;
      5'd12:   m = 21'd87382;
      5'd16:   m = 21'd65536;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/blur3_ctrl.sv
// Sequencer for the blur: steps each sample through read, sum and divide.
// Depends on blur3_pkg for state codes and the command/status structs.
module blur3_ctrl
  import blur3_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SUM;
        end
      end
      S_SUM: begin
        cmd.update = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (!status.res_valid) begin
          state_nxt = S_IDLE;
        end else if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

>>> rtl/core/blur3_dp.sv
// Datapath of the blur: configuration, position counters, line store,
// window registers, weighted sum, reciprocal divide and output register.
// Depends on blur3_pkg; driven by blur3_ctrl through cmd_t.
module blur3_dp
  import blur3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [SAMPLE_W-1:0]   out_filtered_sample,
  output logic                  out_frame_end
);

  // Clamp a dimension to 1..limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > lim) r = lim;
    else r = v;
    return r;
  endfunction

  // Configuration, held clamped
  logic [DIM_W-1:0]  width_r, height_r;
  logic [CHAN_W-1:0] chans_r;
  logic              ksel_r;

  // Position counters
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CHAN_W-1:0] ch_r, ch_nxt;

  // Line store and read path
  logic [LS_DW-1:0]    mem [LS_DEPTH];
  logic [LS_DW-1:0]    rd_q_r;
  logic [LS_AW-1:0]    addr, addr_r;
  logic [SAMPLE_W-1:0] sample_r;

  // Window per channel: [row][column], column 2 newest
  logic [SAMPLE_W-1:0] win_r [MAX_CHANNELS][3][3];

  // Sum stage results
  logic               res_valid_r, res_last_r;
  logic [SUM_W-1:0]   sum_r;
  logic [RECIP_W-1:0] recip_r;

  // Output register
  logic                out_valid_r, out_last_r;
  logic [SAMPLE_W-1:0] out_q_r;

  // Combinational sum stage
  logic [SAMPLE_W-1:0] top, mid;
  logic [SAMPLE_W-1:0] col_in [3];
  logic [SAMPLE_W-1:0] view [3][3];
  logic                row_ok [3];
  logic                col_ok [3];
  logic [1:0]          r_off;
  logic [DIM_W:0]      r_diff;
  logic [DIM_W-1:0]    qr, qc;
  logic                valid, last;
  logic [SUM_W-1:0]    sum;
  logic [2:0]          row_tot, col_tot;
  logic [TOT_W-1:0]    total;
  logic [PROD_W-1:0]   prod;

  assign top = rd_q_r[LS_DW-1:SAMPLE_W];
  assign mid = rd_q_r[SAMPLE_W-1:0];
  assign addr = LS_AW'(ch_r) * LS_AW'(MAX_WIDTH) + LS_AW'(col_r);

  // Output position and validity
  always_comb begin
    r_off  = (col_r == '0) ? 2'd2 : 2'd1;
    r_diff = {1'b0, (DIM_W)'(row_r)} - (DIM_W+1)'(r_off);
    valid  = ((DIM_W)'(row_r) >= (DIM_W)'(r_off)) &&
             (r_diff < {1'b0, height_r});
    qr     = r_diff[DIM_W-1:0];
    qc     = (col_r == '0) ? (width_r - DIM_W'(1)) : ((DIM_W)'(col_r) - DIM_W'(1));
    last   = valid && (qr == height_r - DIM_W'(1)) && (qc == width_r - DIM_W'(1)) &&
             (ch_r == chans_r - CHAN_W'(1));
  end

  // In-frame taps and the weighted sum
  always_comb begin
    col_in[0] = top;
    col_in[1] = mid;
    col_in[2] = sample_r;
    row_ok[0] = (qr != '0);
    row_ok[1] = 1'b1;
    row_ok[2] = ({1'b0, qr} + (DIM_W+1)'(1)) < {1'b0, height_r};
    col_ok[0] = (qc != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = ({1'b0, qc} + (DIM_W+1)'(1)) < {1'b0, width_r};
    for (int i = 0; i < 3; i++) begin
      view[i][0] = win_r[ch_r][i][1];
      view[i][1] = win_r[ch_r][i][2];
      view[i][2] = col_in[i];
    end
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (row_ok[i] && col_ok[k]) begin
          sum = sum + ((SUM_W'(view[i][k])) <<
                       (ksel_r ? (32'(i == 1) + 32'(k == 1)) : 32'd0));
        end
      end
    end
    row_tot = (ksel_r ? 3'd2 : 3'd1) + 3'(row_ok[0]) + 3'(row_ok[2]);
    col_tot = (ksel_r ? 3'd2 : 3'd1) + 3'(col_ok[0]) + 3'(col_ok[2]);
    total   = TOT_W'(row_tot) * TOT_W'(col_tot);
  end

  // Next position
  always_comb begin
    ch_nxt  = ch_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (last) begin
      ch_nxt  = '0;
      col_nxt = '0;
      row_nxt = '0;
    end else if (({1'b0, ch_r} + (CHAN_W+1)'(1)) < {1'b0, chans_r}) begin
      ch_nxt = ch_r + CHAN_W'(1);
    end else begin
      ch_nxt = '0;
      if (({1'b0, col_r} + (COL_W+1)'(1)) < (COL_W+1)'(width_r)) begin
        col_nxt = col_r + COL_W'(1);
      end else begin
        col_nxt = '0;
        if (row_r < ROW_W'(MAX_HEIGHT + 1)) row_nxt = row_r + ROW_W'(1);
      end
    end
  end

  // Configuration writes and position counters; any write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(MAX_HEIGHT);
      chans_r  <= CHAN_W'(1);
      ksel_r   <= 1'b1;
      col_r    <= '0;
      row_r    <= '0;
      ch_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:   width_r  <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
        REG_FRAME_HEIGHT:  height_r <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
        REG_CHANNEL_COUNT: begin
          if (cfg_data[CHAN_W-1:0] == '0) chans_r <= CHAN_W'(1);
          else if (cfg_data[CHAN_W-1:0] > CHAN_W'(MAX_CHANNELS))
            chans_r <= CHAN_W'(MAX_CHANNELS);
          else chans_r <= cfg_data[CHAN_W-1:0];
        end
        REG_KERNEL_SELECT: ksel_r <= cfg_data[0];
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
      ch_r  <= '0;
    end else if (cmd.update) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ch_r  <= ch_nxt;
    end
  end

  // Line store: read on capture, write back shifted lines on update
  always_ff @(posedge clk) begin
    if (cmd.capture) rd_q_r <= mem[addr];
    if (cmd.update) mem[addr_r] <= {mid, sample_r};
  end

  // Hold the sample and its store address
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      addr_r   <= addr;
    end
  end

  // Shift the window of the current channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < MAX_CHANNELS; c++)
        for (int i = 0; i < 3; i++)
          for (int k = 0; k < 3; k++)
            win_r[c][i][k] <= '0;
    end else if (cmd.update) begin
      for (int i = 0; i < 3; i++) begin
        win_r[ch_r][i][0] <= win_r[ch_r][i][1];
        win_r[ch_r][i][1] <= win_r[ch_r][i][2];
        win_r[ch_r][i][2] <= col_in[i];
      end
    end
  end

  // Register the sum and the divisor reciprocal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (cmd.update) begin
      res_valid_r <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_last_r <= last;
      sum_r      <= sum;
      recip_r    <= recip_of(total);
    end
  end

  // Divide by multiplying with the reciprocal
  assign prod = PROD_W'(sum_r) * PROD_W'(recip_r);

  // Output register: load when free, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_q_r    <= prod[RECIP_SHIFT +: SAMPLE_W];
      out_last_r <= res_last_r;
    end
  end

  assign status.res_valid    = res_valid_r;
  assign status.out_busy     = out_valid_r && !out_ready;
  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_q_r;
  assign out_frame_end       = out_last_r;

endmodule

>>> rtl/core/blur_3x3_edge_normalized.sv
// out_valid rises after an input transfer once the read, sum and divide steps
// are done and the output is free. A new sample is taken only after the last one
// leaves the controller's read / sum / divide sequence around the line store's registered read port.
// Reset (rst_n low, synchronous): controller idle, counters and window cleared,
// registers to width 1024, height 1024, one channel, Gaussian kernel.
// The line store is not initialized; there is no clearing pass.
module blur_3x3_edge_normalized
  import blur3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_filtered_sample,
  output logic                  out_frame_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Sequencer
  blur3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  blur3_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_sample           (in_sample),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_filtered_sample (out_filtered_sample),
    .out_frame_end       (out_frame_end)
  );

endmodule

>>> rtl/core/blur3_chk.sv
// Port-level checks for the blur top level, attached by bind.
// Depends on blur3_pkg for port widths.
module blur3_chk
  import blur3_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [SAMPLE_W-1:0] in_sample,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_filtered_sample,
  input logic                out_frame_end
);

  // Stalled input holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_sample))
    else $error("input changed while stalled");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_sample) &&
                                $stable(out_frame_end))
    else $error("result changed while stalled");

  // One sample in flight: ready drops after every input transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while one is in flight");

  // A new result comes only from the divide step, while input is held off
  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared outside the divide step");

endmodule

bind blur_3x3_edge_normalized blur3_chk u_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_sample           (in_sample),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_filtered_sample (out_filtered_sample),
  .out_frame_end       (out_frame_end)
);

>>> test/tb_blur_3x3_edge_normalized.sv
// Testbench for the 3x3 edge-normalized blur: streams whole and cut-off frames
// under varied sizes and kernels and checks every result against a predictor.
// Depends on blur3_pkg and blur_3x3_edge_normalized.
`timescale 1ns / 100ps

module tb_blur_3x3_edge_normalized;
  import blur3_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS = 780;
  // Samples sent on the widest line: past the line end into the next line
  localparam int unsigned WIDE_PREFIX = 1040;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                frame_end;
  } blur_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SAMPLE_W-1:0]   out_filtered_sample;
  logic                  out_frame_end;
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Samples waiting to be sent, and blurred results waiting to come back
  logic [SAMPLE_W-1:0] samples_to_send [$];
  blur_result_t        blur_expected [$];

  // Predictor: register shadows, line stores, windows and input position
  logic [DIM_W-1:0]  width_reg = DIM_W'(MAX_WIDTH);
  logic [DIM_W-1:0]  height_reg = DIM_W'(MAX_HEIGHT);
  logic [CHAN_W-1:0] chans_reg = CHAN_W'(1);
  logic              gauss_reg = 1'b1;
  bit [SAMPLE_W-1:0] line_prev [MAX_CHANNELS][MAX_WIDTH];
  bit [SAMPLE_W-1:0] line_older [MAX_CHANNELS][MAX_WIDTH];
  bit [SAMPLE_W-1:0] win [MAX_CHANNELS][3][3];
  int                col_pos = 0;
  int                row_pos = 0;
  int                chan_pos = 0;

  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_gap = 0;
  int unsigned  recv_stall = 0;
  int unsigned  stall_draw;
  bit           send_calm = 1'b0;
  bit           recv_calm = 1'b0;
  bit           result_due;
  blur_result_t predicted;
  blur_result_t want;

  blur_3x3_edge_normalized u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_filtered_sample (out_filtered_sample),
    .out_frame_end       (out_frame_end),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #4 clk = ~clk;

  // Zero acts as one, values above the limit saturate there
  function automatic int effective(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? int'(hi) : int'(v));
  endfunction

  function automatic int wait_draw(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 12));
  endfunction

  // Advance one channel's window by one column
  function automatic void shift_column(input int ch, input bit [SAMPLE_W-1:0] top,
                                       input bit [SAMPLE_W-1:0] mid,
                                       input bit [SAMPLE_W-1:0] bot);
    int i;
    for (i = 0; i < 3; i++) begin
      win[ch][i][0] = win[ch][i][1];
      win[ch][i][1] = win[ch][i][2];
    end
    win[ch][0][2] = top;
    win[ch][1][2] = mid;
    win[ch][2][2] = bot;
  endfunction

  // Take one sample; return 1 with the blurred result it releases, if any
  function automatic bit blur_predict(input logic [SAMPLE_W-1:0] s,
                                      output blur_result_t res);
    int w, h, nch, ch, c, r, qr, qc, centre, di, dk, wt, sum, total;
    bit [SAMPLE_W-1:0] top, mid;
    bit due, last;
    w = effective(width_reg, MAX_WIDTH);
    h = effective(height_reg, MAX_HEIGHT);
    nch = effective(chans_reg, MAX_CHANNELS);
    ch = (chan_pos >= nch) ? 0 : chan_pos;
    c = (col_pos >= w) ? 0 : col_pos;
    r = row_pos;
    res = '0;
    last = 1'b0;
    top = line_older[ch][c];
    mid = line_prev[ch][c];
    line_older[ch][c] = mid;
    line_prev[ch][c] = s;
    // At column zero the pending pixel is the line end two rows up
    if (c == 0) begin
      centre = 2;
      qr = r - 2;
      qc = w - 1;
    end else begin
      shift_column(ch, top, mid, s);
      centre = 1;
      qr = r - 1;
      qc = c - 1;
    end
    due = (qr >= 0) && (qr < h);
    if (due) begin
      sum = 0;
      total = 0;
      for (di = -1; di <= 1; di++) begin
        for (dk = -1; dk <= 1; dk++) begin
          if (qr + di >= 0 && qr + di < h && qc + dk >= 0 && qc + dk < w) begin
            wt = gauss_reg ? ((di == 0) ? 2 : 1) * ((dk == 0) ? 2 : 1) : 1;
            sum += wt * int'(win[ch][di + 1][centre + dk]);
            total += wt;
          end
        end
      end
      res.value = SAMPLE_W'(sum / total);
      last = (qr == h - 1) && (qc == w - 1) && (ch == nch - 1);
      res.frame_end = last;
    end
    if (c == 0) shift_column(ch, top, mid, s);
    // Advance the input position; wrap to the frame start after the last result
    if (last) begin
      chan_pos = 0;
      col_pos = 0;
      row_pos = 0;
    end else if (ch + 1 < nch) begin
      chan_pos = ch + 1;
      col_pos = c;
    end else begin
      chan_pos = 0;
      if (c + 1 < w) begin
        col_pos = c + 1;
      end else begin
        col_pos = 0;
        if (r < MAX_HEIGHT + 1) row_pos = r + 1;
      end
    end
    return due;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return SAMPLE_W'($urandom_range(0, 255));
  endfunction

  // Queue one frame plus its flush pixels, or a random prefix of it
  function automatic int unsigned queue_frame(input bit whole);
    int unsigned w, h, nch, n, i;
    w = effective(width_reg, MAX_WIDTH);
    h = effective(height_reg, MAX_HEIGHT);
    nch = effective(chans_reg, MAX_CHANNELS);
    n = (w * h + w + 1) * nch;
    if (!whole) n = $urandom_range(1, n - 1);
    for (i = 0; i < n; i++) samples_to_send.push_back(random_sample());
    return n;
  endfunction

  // Register write at the next rising edge; restarts the predicted frame
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_FRAME_WIDTH:   width_reg = v;
      REG_FRAME_HEIGHT:  height_reg = v;
      REG_CHANNEL_COUNT: chans_reg = v[CHAN_W-1:0];
      REG_KERNEL_SELECT: gauss_reg = v[0];
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
    chan_pos = 0;
  endtask

  task automatic cfg_release();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every sample is taken and every result is back, then let
  // the block finish any item that gives no result
  task automatic settle();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || blur_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: predict on each transfer, then present the next sample after its gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_sample <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        result_due = blur_predict(in_sample, predicted);
        if (result_due) blur_expected.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          in_sample <= samples_to_send.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 63) == 0) send_calm = ~send_calm;
          send_gap <= wait_draw(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer against the oldest expectation, then stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (blur_expected.size() == 0) begin
        $error("filtered_sample %0d arrived with no result expected", out_filtered_sample);
        mismatch_count++;
      end else begin
        want = blur_expected.pop_front();
        if (out_filtered_sample !== want.value) begin
          $error("filtered_sample: expected %0d, got %0d", want.value, out_filtered_sample);
          mismatch_count++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, out_frame_end);
          mismatch_count++;
        end
      end
      if ($urandom_range(0, 63) == 0) recv_calm = ~recv_calm;
      stall_draw = wait_draw(recv_calm);
      recv_stall <= stall_draw;
      out_ready <= (stall_draw == 0);
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_ready <= (recv_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_blur_3x3_edge_normalized: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned random_items;
    int unsigned i;
    bit          wrote;
    bit          cut_off;
    bit          whole;
    random_items = 0;
    cut_off = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Start of a line at reset defaults: no result, then cut off by a write
    repeat (4) samples_to_send.push_back(random_sample());
    settle();

    // Zero registers act as a 1x1 single-channel frame; box kernel
    cfg_write(REG_FRAME_WIDTH, '0);
    cfg_write(REG_FRAME_HEIGHT, '0);
    cfg_write(REG_CHANNEL_COUNT, 11'h7FC);
    cfg_write(REG_KERNEL_SELECT, 11'h7FE);
    cfg_release();
    samples_to_send.push_back(8'hFF);
    repeat (2) samples_to_send.push_back(random_sample());
    settle();

    // 2x2 frame, three channels, Gaussian kernel, full-scale samples
    cfg_write(REG_FRAME_WIDTH, 11'd2);
    cfg_write(REG_FRAME_HEIGHT, 11'd2);
    cfg_write(REG_CHANNEL_COUNT, 11'd3);
    cfg_write(REG_KERNEL_SELECT, 11'd1);
    cfg_release();
    for (i = 0; i < 12; i++) samples_to_send.push_back((i[0] ^ i[2]) ? 8'hFF : 8'h00);
    repeat (9) samples_to_send.push_back(random_sample());
    settle();

    // Widest line: width register above the limit, run into the second line
    cfg_write(REG_FRAME_WIDTH, 11'h7FF);
    cfg_write(REG_FRAME_HEIGHT, 11'd1);
    cfg_write(REG_CHANNEL_COUNT, 11'h7FD);
    cfg_write(REG_KERNEL_SELECT, 11'h7FF);
    cfg_release();
    for (i = 0; i < WIDE_PREFIX; i++) samples_to_send.push_back(random_sample());
    cut_off = 1'b1;
    settle();

    // Small random frames, some cut off, with random register changes
    while (random_items < RANDOM_ITEMS) begin
      wrote = 1'b0;
      if ($urandom_range(0, 3) != 0) begin
        cfg_write(REG_FRAME_WIDTH, ($urandom_range(0, 9) == 0) ?
                  DIM_W'($urandom_range(13, 40)) : DIM_W'($urandom_range(0, 12)));
        wrote = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
        cfg_write(REG_FRAME_HEIGHT, ($urandom_range(0, 9) == 0) ?
                  DIM_W'($urandom_range(7, 12)) : DIM_W'($urandom_range(0, 6)));
        wrote = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
        cfg_write(REG_CHANNEL_COUNT, DIM_W'($urandom_range(0, 2047)));
        wrote = 1'b1;
      end
      if ($urandom_range(0, 3) != 0 || (cut_off && !wrote)) begin
        cfg_write(REG_KERNEL_SELECT, DIM_W'($urandom_range(0, 2047)));
        wrote = 1'b1;
      end
      if (wrote) cfg_release();
      whole = ($urandom_range(0, 5) != 0);
      random_items += queue_frame(whole);
      // Run a second frame straight after the first one's end
      if (whole && $urandom_range(0, 2) == 0) random_items += queue_frame(1'b1);
      cut_off = !whole;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("tb_blur_3x3_edge_normalized: PASS");
    end else begin
      $display("tb_blur_3x3_edge_normalized: FAIL");
    end
    $finish;
  end

endmodule
